FILE: hdl/scfd_pkg.sv
package scfd_pkg;

  // Number of drives that can be addressed, 1 to 4.
  localparam int unsigned DRIVE_COUNT = 4;

  localparam logic [7:0] DEV_FIRST = 8'h31;
  localparam logic [7:0] DEV_LAST  = 8'h34;

  // Position of the checksum byte within a frame.
  localparam logic [2:0] POS_CHECKSUM = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CMD_SPEED        = 8'h3f;
  localparam logic [7:0] CMD_FORMAT       = 8'h21;
  localparam logic [7:0] CMD_FORMAT_MED   = 8'h22;
  localparam logic [7:0] CMD_PERCOM_READ  = 8'h4e;
  localparam logic [7:0] CMD_STATUS       = 8'h53;
  localparam logic [7:0] CMD_WRITE        = 8'h50;
  localparam logic [7:0] CMD_WRITE_VERIFY = 8'h57;
  localparam logic [7:0] CMD_READ         = 8'h52;

  typedef enum logic [2:0] {
    OP_NONE         = 3'd0,
    OP_SPEED        = 3'd1,
    OP_FORMAT       = 3'd2,
    OP_PERCOM_READ  = 3'd3,
    OP_STATUS       = 3'd4,
    OP_WRITE        = 3'd5,
    OP_WRITE_VERIFY = 3'd6,
    OP_READ         = 3'd7
  } op_e;

  // A checked frame that addresses a present drive.
  typedef struct packed {
    logic [1:0] drive;
    logic [7:0] cmd;
    logic [7:0] aux_low;
    logic [7:0] aux_high;
  } frame_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

FILE: hdl/scfd_front.sv
module scfd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            rx_byte_i,
  input  logic [2:0]            position_tag_i,
  input  logic                  framing_error_i,
  input  logic [3:0]            drive_present_mask_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output scfd_pkg::frame_t      push_frame_o
);

  logic [2:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] frame_bytes_q [4];
  logic       accept;
  logic       tag_ok;
  logic [8:0] raw_sum;
  logic [7:0] dev_off;
  logic       dev_ok;
  logic       drive_ok;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tag_ok     = !framing_error_i && (position_tag_i == pos_q + 3'd1);
  assign raw_sum    = {1'b0, sum_q} + {1'b0, rx_byte_i};

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept) begin
      if (!tag_ok || pos_q == scfd_pkg::POS_CHECKSUM) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_q + 3'd1;
        // End-around carry; the second add cannot carry again.
        sum_d = raw_sum[7:0] + {7'd0, raw_sum[8]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && tag_ok && pos_q != scfd_pkg::POS_CHECKSUM) begin
      frame_bytes_q[pos_q[1:0]] <= rx_byte_i;
    end
  end

  assign dev_off  = frame_bytes_q[0] - scfd_pkg::DEV_FIRST;
  assign dev_ok   = (frame_bytes_q[0] >= scfd_pkg::DEV_FIRST) &&
                    (frame_bytes_q[0] <= scfd_pkg::DEV_LAST);
  assign drive_ok = ({1'b0, dev_off[1:0]} < 3'(scfd_pkg::DRIVE_COUNT)) &&
                    drive_present_mask_i[dev_off[1:0]];

  assign push_valid_o = accept && tag_ok && (pos_q == scfd_pkg::POS_CHECKSUM) &&
                        (rx_byte_i == sum_q) && dev_ok && drive_ok;

  assign push_frame_o.drive    = dev_off[1:0];
  assign push_frame_o.cmd      = frame_bytes_q[1];
  assign push_frame_o.aux_low  = frame_bytes_q[2];
  assign push_frame_o.aux_high = frame_bytes_q[3];

endmodule

FILE: hdl/scfd_queue.sv
module scfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  scfd_pkg::frame_t push_frame_i,
  output scfd_pkg::hs_t    pop_o,
  input  logic             pop_ready_i,
  output scfd_pkg::frame_t pop_frame_o
);

  localparam int unsigned PtrW = scfd_pkg::QUEUE_PTR_W;
  localparam int unsigned CntW = scfd_pkg::QUEUE_CNT_W;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(scfd_pkg::QUEUE_DEPTH - 1);

  scfd_pkg::frame_t  mem_q [scfd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (count_q != CntW'(scfd_pkg::QUEUE_DEPTH));
  assign pop_o.valid  = (count_q != '0);
  assign pop_o.ready  = pop_ready_i;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_o.valid && pop_ready_i;
  assign pop_frame_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(scfd_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not grow on push");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

FILE: hdl/scfd_back.sv
module scfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scfd_pkg::hs_t    pop_i,
  output logic             pop_ready_o,
  input  scfd_pkg::frame_t pop_frame_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             accepted_o,
  output logic [2:0]       operation_o,
  output logic [1:0]       drive_index_o,
  output logic [7:0]       command_byte_o,
  output logic [7:0]       aux_low_o,
  output logic [7:0]       aux_high_o,
  output logic [15:0]      sector_number_o
);

  logic              valid_q, valid_d;
  scfd_pkg::frame_t  frame_q;
  scfd_pkg::op_e     op_q, op_d;
  logic              load;
  logic              sector_nz;

  // The output register takes a new frame whenever it is empty or is being drained.
  assign pop_ready_o = !valid_q || out_ready_i;
  assign load        = pop_i.valid && pop_ready_o;
  assign sector_nz   = (pop_frame_i.aux_low != '0) || (pop_frame_i.aux_high != '0);

  always_comb begin
    case (pop_frame_i.cmd)
      scfd_pkg::CMD_SPEED:        op_d = scfd_pkg::OP_SPEED;
      scfd_pkg::CMD_FORMAT:       op_d = scfd_pkg::OP_FORMAT;
      scfd_pkg::CMD_FORMAT_MED:   op_d = scfd_pkg::OP_FORMAT;
      scfd_pkg::CMD_PERCOM_READ:  op_d = scfd_pkg::OP_PERCOM_READ;
      scfd_pkg::CMD_STATUS:       op_d = scfd_pkg::OP_STATUS;
      scfd_pkg::CMD_WRITE:
        op_d = sector_nz ? scfd_pkg::OP_WRITE : scfd_pkg::OP_NONE;
      scfd_pkg::CMD_WRITE_VERIFY:
        op_d = sector_nz ? scfd_pkg::OP_WRITE_VERIFY : scfd_pkg::OP_NONE;
      scfd_pkg::CMD_READ:
        op_d = sector_nz ? scfd_pkg::OP_READ : scfd_pkg::OP_NONE;
      default:                    op_d = scfd_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= pop_frame_i;
      op_q    <= op_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign accepted_o      = (op_q != scfd_pkg::OP_NONE);
  assign operation_o     = op_q;
  assign drive_index_o   = frame_q.drive;
  assign command_byte_o  = frame_q.cmd;
  assign aux_low_o       = frame_q.aux_low;
  assign aux_high_o      = frame_q.aux_high;
  assign sector_number_o = {frame_q.aux_high, frame_q.aux_low};

endmodule

FILE: hdl/serial_command_frame_decoder.sv
// Serial command frame decoder.
// Input channel (in_valid_i/in_ready_o) takes one received byte per transaction with
// its position tag and framing-error flag. Five good bytes in a row (device, command,
// aux low, aux high, checksum) form a command frame; a bad tag or framing error drops
// the partial frame and gathering restarts with the next byte.
// Output channel (out_valid_o/out_ready_i) delivers one transaction per frame that
// passes the checksum and addresses a mounted drive: ACK or NACK with the operation
// and the frame fields. Other frames produce nothing.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes the drive present mask and is
// always ready. Users must write it only while the block is idle (not enforced).
// Throughput: one byte per cycle unless the frame queue is full. The frame enters the
// queue at the edge that accepts the checksum byte and moves into the output register
// which drives out_valid_o, once that register is empty or is being drained.
// The front end stalls input only when its two-entry frame queue is full, so a stalled
// receiver holds its result while up to two more frames are gathered.
// Reset clears the byte position, the running sum, the queue, the output valid flag and
// the mask, so no drive is present until it is written.
module serial_command_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_drive_present_mask_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [2:0]  position_tag_i,
  input  logic        framing_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  operation_o,
  output logic [1:0]  drive_index_o,
  output logic [7:0]  command_byte_o,
  output logic [7:0]  aux_low_o,
  output logic [7:0]  aux_high_o,
  output logic [15:0] sector_number_o
);

  logic [3:0]       mask_q;
  logic             push_valid;
  logic             push_ready;
  scfd_pkg::frame_t push_frame;
  scfd_pkg::hs_t    pop_hs;
  logic             pop_ready;
  scfd_pkg::frame_t pop_frame;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_q <= cfg_drive_present_mask_i;
    end
  end

  scfd_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .rx_byte_i            (rx_byte_i),
    .position_tag_i       (position_tag_i),
    .framing_error_i      (framing_error_i),
    .drive_present_mask_i (mask_q),
    .push_valid_o         (push_valid),
    .push_ready_i         (push_ready),
    .push_frame_o         (push_frame)
  );

  scfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_frame_i (push_frame),
    .pop_o        (pop_hs),
    .pop_ready_i  (pop_ready),
    .pop_frame_o  (pop_frame)
  );

  scfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_i           (pop_hs),
    .pop_ready_o     (pop_ready),
    .pop_frame_i     (pop_frame),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .operation_o     (operation_o),
    .drive_index_o   (drive_index_o),
    .command_byte_o  (command_byte_o),
    .aux_low_o       (aux_low_o),
    .aux_high_o      (aux_high_o),
    .sector_number_o (sector_number_o)
  );

endmodule

FILE: verif/serial_command_frame_decoder_test.sv
`timescale 1ns / 1ps

module serial_command_frame_decoder_test;

  localparam int FRAME_BYTES = 5;
  localparam int STALL_CYCLES = 80;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] tag;
    logic       ferr;
  } serial_byte_t;

  typedef struct packed {
    logic          accepted;
    scfd_pkg::op_e op;
    logic [1:0]    drive;
    logic [7:0]    cmd;
    logic [7:0]    aux_low;
    logic [7:0]    aux_high;
    logic [15:0]   sector;
  } frame_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_drive_present_mask_i = 4'h0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic [2:0]  position_tag_i = 3'd0;
  logic        framing_error_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        accepted_o;
  logic [2:0]  operation_o;
  logic [1:0]  drive_index_o;
  logic [7:0]  command_byte_o;
  logic [7:0]  aux_low_o;
  logic [7:0]  aux_high_o;
  logic [15:0] sector_number_o;

  serial_command_frame_decoder dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_drive_present_mask_i (cfg_drive_present_mask_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .rx_byte_i                (rx_byte_i),
    .position_tag_i           (position_tag_i),
    .framing_error_i          (framing_error_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .accepted_o               (accepted_o),
    .operation_o              (operation_o),
    .drive_index_o            (drive_index_o),
    .command_byte_o           (command_byte_o),
    .aux_low_o                (aux_low_o),
    .aux_high_o               (aux_high_o),
    .sector_number_o          (sector_number_o)
  );

  serial_byte_t byte_queue[$];
  frame_reply_t expected_replies[$];

  // Frame gathering state of the predictor.
  logic [2:0] frame_pos = 3'd0;
  logic [7:0] frame_buf[4];
  logic [7:0] frame_sum = 8'h00;
  logic [3:0] mask_model = 4'h0;

  bit in_fire;
  bit steady;
  int bytes_queued;
  int bytes_accepted;
  int mismatches;
  int replies_seen;
  int ack_count;
  int nack_count;
  int mask_writes;
  int stall_requests;
  int stalls_served;
  int stall_left;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Timeout: the decoder stopped making progress.");
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] add_carry_around(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, acc} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

  function automatic logic [7:0] frame_checksum(input logic [7:0] dev, input logic [7:0] cmd,
                                                input logic [7:0] a1, input logic [7:0] a2);
    return add_carry_around(add_carry_around(add_carry_around(dev, cmd), a1), a2);
  endfunction

  function automatic scfd_pkg::op_e decode_command(input logic [7:0] cmd,
                                                   input logic has_sector);
    case (cmd)
      scfd_pkg::CMD_SPEED:        return scfd_pkg::OP_SPEED;
      scfd_pkg::CMD_FORMAT:       return scfd_pkg::OP_FORMAT;
      scfd_pkg::CMD_FORMAT_MED:   return scfd_pkg::OP_FORMAT;
      scfd_pkg::CMD_PERCOM_READ:  return scfd_pkg::OP_PERCOM_READ;
      scfd_pkg::CMD_STATUS:       return scfd_pkg::OP_STATUS;
      scfd_pkg::CMD_WRITE:
        return has_sector ? scfd_pkg::OP_WRITE : scfd_pkg::OP_NONE;
      scfd_pkg::CMD_WRITE_VERIFY:
        return has_sector ? scfd_pkg::OP_WRITE_VERIFY : scfd_pkg::OP_NONE;
      scfd_pkg::CMD_READ:
        return has_sector ? scfd_pkg::OP_READ : scfd_pkg::OP_NONE;
      default:                    return scfd_pkg::OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] pick_command(input int idx);
    case (idx)
      0:       return scfd_pkg::CMD_SPEED;
      1:       return scfd_pkg::CMD_FORMAT;
      2:       return scfd_pkg::CMD_FORMAT_MED;
      3:       return scfd_pkg::CMD_PERCOM_READ;
      4:       return scfd_pkg::CMD_STATUS;
      5:       return scfd_pkg::CMD_WRITE;
      6:       return scfd_pkg::CMD_WRITE_VERIFY;
      default: return scfd_pkg::CMD_READ;
    endcase
  endfunction

  // Advances the predicted frame state by one accepted byte.
  task automatic absorb_byte(input serial_byte_t b);
    frame_reply_t r;
    logic [7:0] dev;
    logic [7:0] want_sum;
    int drive;
    if (frame_pos >= FRAME_BYTES) begin
      frame_pos = 3'd0;
      frame_sum = 8'h00;
    end
    if (b.ferr || b.tag != frame_pos + 1) begin
      frame_pos = 3'd0;
      frame_sum = 8'h00;
    end else if (frame_pos < scfd_pkg::POS_CHECKSUM) begin
      frame_buf[frame_pos[1:0]] = b.data;
      frame_sum = add_carry_around(frame_sum, b.data);
      frame_pos = frame_pos + 3'd1;
    end else begin
      want_sum = frame_sum;
      frame_pos = 3'd0;
      frame_sum = 8'h00;
      dev = frame_buf[0];
      if (want_sum == b.data && dev >= scfd_pkg::DEV_FIRST && dev <= scfd_pkg::DEV_LAST) begin
        drive = dev - scfd_pkg::DEV_FIRST;
        if (drive < scfd_pkg::DRIVE_COUNT && mask_model[drive]) begin
          r.cmd = frame_buf[1];
          r.aux_low = frame_buf[2];
          r.aux_high = frame_buf[3];
          r.sector = {frame_buf[3], frame_buf[2]};
          r.drive = drive[1:0];
          r.op = decode_command(r.cmd, r.sector != 16'd0);
          r.accepted = (r.op != scfd_pkg::OP_NONE);
          expected_replies.push_back(r);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (reply %0d)", what, got, want,
             replies_seen);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : monitor
    frame_reply_t want;
    serial_byte_t taken;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        mask_model = cfg_drive_present_mask_i;
        mask_writes++;
      end
      if (in_fire) begin
        taken.data = rx_byte_i;
        taken.tag = position_tag_i;
        taken.ferr = framing_error_i;
        absorb_byte(taken);
        bytes_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing pending", {8'd0, command_byte_o}, 16'd0);
        end else begin
          want = expected_replies.pop_front();
          if (accepted_o !== want.accepted)
            report_mismatch("accepted", {15'd0, accepted_o}, {15'd0, want.accepted});
          if (operation_o !== want.op)
            report_mismatch("operation", {13'd0, operation_o}, {13'd0, want.op});
          if (drive_index_o !== want.drive)
            report_mismatch("drive_index", {14'd0, drive_index_o}, {14'd0, want.drive});
          if (command_byte_o !== want.cmd)
            report_mismatch("command_byte", {8'd0, command_byte_o}, {8'd0, want.cmd});
          if (aux_low_o !== want.aux_low)
            report_mismatch("aux_low", {8'd0, aux_low_o}, {8'd0, want.aux_low});
          if (aux_high_o !== want.aux_high)
            report_mismatch("aux_high", {8'd0, aux_high_o}, {8'd0, want.aux_high});
          if (sector_number_o !== want.sector)
            report_mismatch("sector_number", sector_number_o, want.sector);
          if (want.accepted) ack_count++;
          else nack_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    serial_byte_t nxt;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (byte_queue.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
        nxt = byte_queue.pop_front();
        in_valid_i <= 1'b1;
        rx_byte_i <= nxt.data;
        position_tag_i <= nxt.tag;
        framing_error_i <= nxt.ferr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver stalls for a long stretch each time one is requested.
  always @(negedge clk_i) begin : receiver
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stalls_served != stall_requests) begin
      stalls_served <= stalls_served + 1;
      stall_left <= STALL_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 13);
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic [2:0] tag, input logic ferr);
    serial_byte_t b;
    b.data = data;
    b.tag = tag;
    b.ferr = ferr;
    byte_queue.push_back(b);
    bytes_queued++;
  endtask

  // Queues the first count bytes of a frame; the last queued byte carries last_ferr.
  task automatic push_frame_upto(input logic [7:0] dev, input logic [7:0] cmd,
                                 input logic [7:0] a1, input logic [7:0] a2,
                                 input logic [7:0] sum, input int count, input logic last_ferr);
    logic [7:0] fb[5];
    fb[0] = dev;
    fb[1] = cmd;
    fb[2] = a1;
    fb[3] = a2;
    fb[4] = sum;
    for (int i = 0; i < count; i++)
      push_byte(fb[i], 3'(i + 1), (i == count - 1) ? last_ferr : 1'b0);
  endtask

  task automatic push_frame(input logic [7:0] dev, input logic [7:0] cmd,
                            input logic [7:0] a1, input logic [7:0] a2);
    push_frame_upto(dev, cmd, a1, a2, frame_checksum(dev, cmd, a1, a2), FRAME_BYTES, 1'b0);
  endtask

  task automatic roll_frame(output logic [7:0] dev, output logic [7:0] cmd,
                            output logic [7:0] a1, output logic [7:0] a2);
    int r;
    dev = ($urandom_range(99) < 85) ? 8'(scfd_pkg::DEV_FIRST + $urandom_range(3))
                                    : 8'($urandom);
    cmd = ($urandom_range(99) < 85) ? pick_command($urandom_range(7)) : 8'($urandom);
    a1 = 8'($urandom);
    a2 = 8'($urandom);
    r = $urandom_range(99);
    if (r < 20) begin
      a1 = 8'h00;
      a2 = 8'h00;
    end else if (r < 30) begin
      a1 = 8'h00;
    end
  endtask

  task automatic push_random_frame();
    logic [7:0] dev, cmd, a1, a2, sum;
    roll_frame(dev, cmd, a1, a2);
    sum = frame_checksum(dev, cmd, a1, a2);
    if ($urandom_range(99) < 10)
      sum = sum ^ (8'd1 << $urandom_range(7));
    push_frame_upto(dev, cmd, a1, a2, sum, FRAME_BYTES, 1'b0);
  endtask

  // Noise and broken frames; each one leaves the decoder back at the first position.
  task automatic push_broken_sequence();
    logic [7:0] dev, cmd, a1, a2;
    int k;
    roll_frame(dev, cmd, a1, a2);
    k = $urandom_range(1, 4);
    case ($urandom_range(3))
      0: begin
        repeat ($urandom_range(1, 3))
          push_byte(8'($urandom), 3'($urandom_range(7)), 1'($urandom_range(1)));
        push_byte(8'($urandom), 3'($urandom_range(7)), 1'b1);
      end
      1: push_frame_upto(dev, cmd, a1, a2, frame_checksum(dev, cmd, a1, a2), k + 1, 1'b1);
      2: begin
        push_frame_upto(dev, cmd, a1, a2, frame_checksum(dev, cmd, a1, a2), k, 1'b0);
        push_byte(8'($urandom), 3'(k + 1 + $urandom_range(1, 7)), 1'b0);
      end
      default:
        push_frame_upto(dev, cmd, a1, a2, frame_checksum(dev, cmd, a1, a2), FRAME_BYTES, 1'b1);
    endcase
  endtask

  task automatic push_random_traffic(input int n);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      if ($urandom_range(99) < 75) push_random_frame();
      else push_broken_sequence();
    end
  endtask

  task automatic wait_for_idle();
    while (bytes_accepted != bytes_queued || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_drive_mask(input logic [3:0] mask);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_drive_present_mask_i <= mask;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No drive is mounted after reset, so good frames stay silent.
    push_frame(8'h31, scfd_pkg::CMD_STATUS, 8'h01, 8'h00);
    push_frame(8'h34, scfd_pkg::CMD_READ, 8'h01, 8'h00);
    wait_for_idle();

    write_drive_mask(4'hF);
    push_frame(8'h31, scfd_pkg::CMD_SPEED, 8'h00, 8'h00);
    push_frame(8'h32, scfd_pkg::CMD_FORMAT, 8'hFF, 8'hFF);
    push_frame(8'h33, scfd_pkg::CMD_FORMAT_MED, 8'h00, 8'h00);
    push_frame(8'h34, scfd_pkg::CMD_PERCOM_READ, 8'h12, 8'h34);
    push_frame(8'h31, scfd_pkg::CMD_STATUS, 8'h00, 8'h00);
    push_frame(8'h32, scfd_pkg::CMD_WRITE, 8'h01, 8'h00);
    push_frame(8'h33, scfd_pkg::CMD_WRITE, 8'h00, 8'h00);
    push_frame(8'h34, scfd_pkg::CMD_WRITE_VERIFY, 8'h00, 8'h01);
    push_frame(8'h31, scfd_pkg::CMD_WRITE_VERIFY, 8'h00, 8'h00);
    push_frame(8'h32, scfd_pkg::CMD_READ, 8'hFF, 8'hFF);
    push_frame(8'h33, scfd_pkg::CMD_READ, 8'h00, 8'h00);
    push_frame(8'h34, 8'h00, 8'h00, 8'h00);
    push_frame(8'h34, 8'hFF, 8'hFF, 8'hFF);
    push_frame_upto(8'h31, scfd_pkg::CMD_STATUS, 8'h05, 8'h00,
                    frame_checksum(8'h31, scfd_pkg::CMD_STATUS, 8'h05, 8'h00) + 8'd1,
                    FRAME_BYTES, 1'b0);
    push_frame(8'h30, scfd_pkg::CMD_STATUS, 8'h01, 8'h00);
    push_frame(8'h35, scfd_pkg::CMD_STATUS, 8'h01, 8'h00);
    push_frame(8'h00, scfd_pkg::CMD_READ, 8'h01, 8'h00);
    push_frame(8'hFF, scfd_pkg::CMD_READ, 8'hFF, 8'hFF);
    // Framing error in the middle of a frame, then a clean frame.
    push_frame_upto(8'h32, scfd_pkg::CMD_READ, 8'h07, 8'h00, 8'h00, 3, 1'b1);
    push_frame(8'h32, scfd_pkg::CMD_READ, 8'h07, 8'h00);
    // Wrong tags: at the first position and as a repeated tag mid-frame.
    push_byte(8'h31, 3'd0, 1'b0);
    push_frame_upto(8'h33, scfd_pkg::CMD_WRITE, 8'h09, 8'h00, 8'h00, 2, 1'b0);
    push_byte(8'h09, 3'd2, 1'b0);
    push_frame(8'h33, scfd_pkg::CMD_WRITE, 8'h09, 8'h00);
    // Framing error on an otherwise good checksum byte.
    push_frame_upto(8'h34, scfd_pkg::CMD_STATUS, 8'h00, 8'h00,
                    frame_checksum(8'h34, scfd_pkg::CMD_STATUS, 8'h00, 8'h00),
                    FRAME_BYTES, 1'b1);
    wait_for_idle();

    write_drive_mask(4'h5);
    push_frame(8'h32, scfd_pkg::CMD_STATUS, 8'h00, 8'h00);
    push_random_traffic(80);
    wait_for_idle();

    // Receiver holds off while the sender keeps streaming good frames.
    write_drive_mask(4'hF);
    steady = 1'b1;
    stall_requests++;
    repeat (20)
      push_frame(8'(scfd_pkg::DEV_FIRST + $urandom_range(3)), pick_command($urandom_range(7)),
                 8'($urandom_range(1, 255)), 8'($urandom));
    wait_for_idle();
    steady = 1'b0;

    write_drive_mask(4'hA);
    push_random_traffic(80);
    wait_for_idle();

    write_drive_mask(4'($urandom_range(15)));
    push_random_traffic(80);
    wait_for_idle();

    write_drive_mask(4'hF);
    steady = 1'b1;
    push_random_traffic(80);
    wait_for_idle();
    steady = 1'b0;

    write_drive_mask(4'h0);
    push_random_traffic(30);
    wait_for_idle();

    if (expected_replies.size() != 0)
      report_mismatch("replies never delivered", 16'(expected_replies.size()), 16'd0);
    $display("Sent %0d serial bytes; checked %0d replies (%0d ACK, %0d NACK).",
             bytes_accepted, replies_seen, ack_count, nack_count);
    $display("Drive mask written %0d times, empty and full included; %0d long receiver stall.",
             mask_writes, stalls_served);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
